// ===== hw/rtl/page_replacement_fifo_lru_defines.svh =====
// Assertion macros shared by the frame table RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef PAGE_REPLACEMENT_FIFO_LRU_DEFINES_SVH
`define PAGE_REPLACEMENT_FIFO_LRU_DEFINES_SVH

// Check that a condition holds at every clock edge.
`define PFL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequence holds in the same cycle as its trigger.
`define PFL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequence holds in the cycle after its trigger.
`define PFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pfl_pkg.sv =====
// Shared constants, codes and types of the page frame table.
// No dependencies; imported by every module of the block.
package pfl_pkg;

  // Sizes
  localparam int MAX_FRAMES = 8;
  localparam int SLOT_W     = 3;
  localparam int FC_W       = 4;
  localparam int PAGE_W     = 8;
  localparam int FAULT_W    = 16;

  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;
  localparam logic [FC_W-1:0]    FC_ONE    = FC_W'(1);
  localparam logic [FC_W-1:0]    FC_RESET  = FC_W'(MAX_FRAMES);

  // Command queue between front and back (depth is a power of two)
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // Register indexes
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_POLICY      = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_COUNT = 1'b1;

  // Operation codes
  localparam logic OP_REF   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Replacement policies
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  // Decoded command word
  typedef struct packed {
    logic              clear;
    logic [PAGE_W-1:0] page;
  } cmd_t;

endpackage

// ===== hw/rtl/pfl_front.sv =====
// Front end: accepts input words, decodes the op and queues commands.
// Depends on pfl_pkg and the assertion macros header.
`include "page_replacement_fifo_lru_defines.svh"

module pfl_front import pfl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              op,
  input  logic [PAGE_W-1:0] page,
  output logic              full,
  input  logic              q_take,
  output logic              q_valid,
  output cmd_t              q_cmd
);

  cmd_t                 q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   q_cnt;
  logic                 accept;
  cmd_t                 cmd_in;

  // Decode the incoming word; a clear carries no page
  always_comb begin
    cmd_in.clear = (op == OP_CLEAR);
    cmd_in.page  = (op == OP_CLEAR) ? '0 : page;
  end

  assign full    = (q_cnt == Q_CNT_W'(Q_DEPTH));
  assign accept  = push && !full;
  assign q_valid = (q_cnt != '0);
  assign q_cmd   = q_mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_cnt  <= '0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + Q_PTR_W'(1);
      if (q_take) rd_ptr <= rd_ptr + Q_PTR_W'(1);
      if (accept && !q_take) q_cnt <= q_cnt + Q_CNT_W'(1);
      else if (!accept && q_take) q_cnt <= q_cnt - Q_CNT_W'(1);
    end
  end

  // Store the decoded word
  always_ff @(posedge clk) begin
    if (accept) q_mem[wr_ptr] <= cmd_in;
  end

  `PFL_ASSERT_IMPL(a_take_nonempty, q_take, q_cnt != '0, "command taken from empty queue")

endmodule

// ===== hw/rtl/pfl_back.sv =====
// Back end: frame table, replacement update, configuration and report sequencer.
// Depends on pfl_pkg and the assertion macros header.
`include "page_replacement_fifo_lru_defines.svh"

module pfl_back import pfl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [FC_W-1:0]      wr_data,
  input  logic                 q_valid,
  input  cmd_t                 q_cmd,
  output logic                 q_take,
  output logic                 empty,
  input  logic                 pop,
  output logic [SLOT_W-1:0]    slot,
  output logic [PAGE_W-1:0]    slot_page,
  output logic                 slot_valid,
  output logic                 fault,
  output logic [FAULT_W-1:0]   fault_number,
  output logic                 last
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_REPORT = 1'b1;

  // Configuration
  logic              policy;
  logic [FC_W-1:0]   frame_count;
  logic [FC_W-1:0]   n_use;

  // Frame table
  logic [PAGE_W-1:0]     page_q [MAX_FRAMES];
  logic [PAGE_W-1:0]     page_up [MAX_FRAMES];
  logic [PAGE_W-1:0]     page_next [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_q;
  logic [MAX_FRAMES-1:0] valid_next;
  logic [SLOT_W-1:0]     ptr;
  logic [SLOT_W-1:0]     ptr_c;
  logic [SLOT_W-1:0]     ptr_next;
  logic [FC_W-1:0]       filled;
  logic [FC_W-1:0]       filled_c;
  logic [FC_W-1:0]       filled_next;
  logic [FAULT_W-1:0]    fault_cnt;
  logic [MAX_FRAMES-1:0] fill_mask;

  // Lookup
  logic [MAX_FRAMES-1:0] hit;
  logic [MAX_FRAMES-1:0] at_or_past_hit;
  logic                  fault_c;

  // Report sequencer
  logic              state;
  logic [SLOT_W-1:0] rpt_slot;
  logic              rpt_last;
  logic              fault_r;
  logic [FAULT_W-1:0] before_r;
  logic              out_valid;
  logic              load;
  logic              last_load;

  // Clamp the frame count to the built range
  always_comb begin
    if (frame_count == '0) n_use = FC_ONE;
    else if (frame_count > FC_RESET) n_use = FC_RESET;
    else n_use = frame_count;
  end

  assign filled_c = (filled > n_use) ? n_use : filled;
  assign ptr_c    = ({1'b0, ptr} >= n_use) ? '0 : ptr;

  // Next-newer neighbor of each frame, for stack shifts
  genvar g;
  generate
    for (g = 0; g < MAX_FRAMES; g++) begin : g_up
      if (g < MAX_FRAMES - 1) begin : g_mid
        assign page_up[g] = page_q[g+1];
      end else begin : g_top
        assign page_up[g] = page_q[g];
      end
    end
  endgenerate

  // Search frames in use and mark everything from the first hit upward
  always_comb begin
    for (int k = 0; k < MAX_FRAMES; k++) begin
      hit[k] = valid_q[k] && (page_q[k] == q_cmd.page) && (FC_W'(k) < n_use);
      fill_mask[k] = (FC_W'(k) < filled);
    end
    at_or_past_hit[0] = hit[0];
    for (int k = 1; k < MAX_FRAMES; k++) begin
      at_or_past_hit[k] = at_or_past_hit[k-1] | hit[k];
    end
  end

  assign fault_c = ~|hit;

  // Work out the table after this reference
  always_comb begin
    page_next   = page_q;
    valid_next  = valid_q;
    ptr_next    = ptr_c;
    filled_next = filled_c;
    if (policy == POLICY_FIFO) begin
      if (fault_c) begin
        page_next[ptr_c]  = q_cmd.page;
        valid_next[ptr_c] = 1'b1;
        if (!valid_q[ptr_c] && (filled_c < n_use)) filled_next = filled_c + FC_ONE;
        ptr_next = (({1'b0, ptr_c} + FC_ONE) >= n_use) ? '0 : ptr_c + SLOT_W'(1);
      end
    end else begin
      if (!fault_c) begin
        // move the hit page to the newest end
        for (int k = 0; k < MAX_FRAMES; k++) begin
          if (at_or_past_hit[k] && (FC_W'(k + 1) < filled_c)) page_next[k] = page_up[k];
          else if (FC_W'(k + 1) == filled_c) page_next[k] = q_cmd.page;
        end
      end else if (filled_c < n_use) begin
        // append above the newest
        page_next[filled_c[SLOT_W-1:0]]  = q_cmd.page;
        valid_next[filled_c[SLOT_W-1:0]] = 1'b1;
        filled_next = filled_c + FC_ONE;
      end else begin
        // drop the oldest and append
        for (int k = 0; k < MAX_FRAMES; k++) begin
          if (FC_W'(k + 1) < n_use) page_next[k] = page_up[k];
          else if (FC_W'(k + 1) == n_use) page_next[k] = q_cmd.page;
        end
      end
    end
  end

  // Sequencer handshakes
  assign rpt_last  = (({1'b0, rpt_slot} + FC_ONE) == n_use);
  assign load      = (state == ST_REPORT) && (!out_valid || pop);
  assign last_load = load && rpt_last;
  assign q_take    = q_valid && ((state == ST_IDLE) || last_load);
  assign empty     = !out_valid;

  // Control state: configuration, table status, counters
  always_ff @(posedge clk) begin
    if (rst) begin
      policy      <= POLICY_FIFO;
      frame_count <= FC_RESET;
      valid_q     <= '0;
      ptr         <= '0;
      filled      <= '0;
      fault_cnt   <= '0;
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_POLICY:      policy <= wr_data[0];
          REG_FRAME_COUNT: frame_count <= wr_data;
          default: ;
        endcase
        valid_q   <= '0;
        ptr       <= '0;
        filled    <= '0;
        fault_cnt <= '0;
      end else if (q_take) begin
        if (q_cmd.clear) begin
          valid_q   <= '0;
          ptr       <= '0;
          filled    <= '0;
          fault_cnt <= '0;
          state     <= ST_IDLE;
        end else begin
          valid_q <= valid_next;
          ptr     <= ptr_next;
          filled  <= filled_next;
          if (fault_c && (fault_cnt != FAULT_MAX)) fault_cnt <= fault_cnt + FAULT_W'(1);
          state   <= ST_REPORT;
        end
      end else if (last_load) begin
        state <= ST_IDLE;
      end

      if (load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  // Payload: page store, report context, output word
  always_ff @(posedge clk) begin
    if (q_take && !q_cmd.clear) begin
      page_q   <= page_next;
      fault_r  <= fault_c;
      before_r <= fault_cnt;
      rpt_slot <= '0;
    end else if (load) begin
      rpt_slot <= rpt_slot + SLOT_W'(1);
    end
    if (load) begin
      slot         <= rpt_slot;
      slot_page    <= valid_q[rpt_slot] ? page_q[rpt_slot] : '0;
      slot_valid   <= valid_q[rpt_slot];
      fault        <= fault_r;
      fault_number <= before_r;
      last         <= rpt_last;
    end
  end

  `PFL_ASSERT_ALWAYS(a_fill_count, $countones(valid_q) == filled, "fill count disagrees with valid bits")
  `PFL_ASSERT_IMPL(a_lru_packed, policy == POLICY_LRU, valid_q == fill_mask, "LRU stack has a hole")
  `PFL_ASSERT_IMPL(a_slot_range, state == ST_REPORT, {1'b0, rpt_slot} < n_use, "report past frames in use")
  `PFL_ASSERT_NEXT(a_fault_step, q_take && !wr_en && !q_cmd.clear && fault_c && (fault_cnt != FAULT_MAX), fault_cnt == $past(fault_cnt) + FAULT_W'(1), "fault counter missed a fault")

endmodule

// ===== hw/rtl/page_replacement_fifo_lru.sv =====
// Page frame table with FIFO or LRU replacement (top level; uses pfl_pkg, pfl_front,
// pfl_back). Words enter through a push/full port and decoded commands wait in a two-deep
// queue; the back end updates the table for a reference, then reports every frame in
// use (1 to 8), one result word per cycle while pop is held, through a registered pop/empty
// port; the next reference is taken as the last report word of the one before is loaded.
// A clear reports nothing. Write policy or frame_count only while idle: any write also
// empties the table and the fault counter.
module page_replacement_fifo_lru import pfl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 op,
  input  logic [PAGE_W-1:0]    page,
  output logic                 empty,
  input  logic                 pop,
  output logic [SLOT_W-1:0]    slot,
  output logic [PAGE_W-1:0]    slot_page,
  output logic                 slot_valid,
  output logic                 fault,
  output logic [FAULT_W-1:0]   fault_number,
  output logic                 last,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [FC_W-1:0]      wr_data
);

  logic q_valid;
  logic q_take;
  cmd_t q_cmd;

  // Accept and decode
  pfl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .op      (op),
    .page    (page),
    .full    (full),
    .q_take  (q_take),
    .q_valid (q_valid),
    .q_cmd   (q_cmd)
  );

  // Update table and report
  pfl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_take       (q_take),
    .empty        (empty),
    .pop          (pop),
    .slot         (slot),
    .slot_page    (slot_page),
    .slot_valid   (slot_valid),
    .fault        (fault),
    .fault_number (fault_number),
    .last         (last)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the page frame table with FIFO and LRU replacement.
// Depends on pfl_pkg and page_replacement_fifo_lru; a scoreboard class predicts every
// slot report, tasks drive the push/full and register write ports, and an always block drives pop.
`timescale 1ns / 100ps

module tb_top;
  import pfl_pkg::*;

  localparam int STALL_PCT  = 31;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASE_WORDS = 17;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [PAGE_W-1:0]  pg;
    logic               vld;
    logic               flt;
    logic [FAULT_W-1:0] fnum;
    logic               lst;
  } report_t;

  // Frame table predictor plus the store of slot reports still owed by the block
  class frame_table_scoreboard;
    logic               policy_q;
    logic [FC_W-1:0]    frame_count_q;
    logic [PAGE_W-1:0]  frame_page [MAX_FRAMES];
    logic               frame_valid [MAX_FRAMES];
    logic [SLOT_W-1:0]  fifo_ptr;
    logic [FC_W-1:0]    filled;
    logic [FAULT_W-1:0] fault_cnt;
    report_t            report_q [$];
    int                 errors;

    function new();
      policy_q      = POLICY_FIFO;
      frame_count_q = FC_RESET;
      errors        = 0;
      empty_table();
    endfunction

    function void empty_table();
      foreach (frame_valid[k]) begin
        frame_valid[k] = 1'b0;
        frame_page[k]  = '0;
      end
      fifo_ptr  = '0;
      filled    = '0;
      fault_cnt = '0;
    endfunction

    // Any register write also empties the table
    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [FC_W-1:0] data);
      case (idx)
        REG_POLICY:      policy_q = data[0];
        REG_FRAME_COUNT: frame_count_q = data;
        default: ;
      endcase
      empty_table();
    endfunction

    // Zero acts as one frame, anything past the table acts as the full table
    function int frames_in_use();
      if (frame_count_q == '0) return 1;
      if (frame_count_q > MAX_FRAMES) return MAX_FRAMES;
      return int'(frame_count_q);
    endfunction

    // Update the table for one accepted word and queue the slot reports it causes
    function void predict_frames(logic o, logic [PAGE_W-1:0] pg);
      int                 n;
      int                 hit_at;
      logic               miss;
      logic [FAULT_W-1:0] count_before;
      report_t            r;
      n = frames_in_use();
      if (o == OP_CLEAR) begin
        empty_table();
        return;
      end
      if (filled > n) filled = FC_W'(n);
      if (fifo_ptr >= n) fifo_ptr = '0;

      // lowest valid slot holding the page
      hit_at = n;
      for (int k = n - 1; k >= 0; k--)
        if (frame_valid[k] && frame_page[k] == pg) hit_at = k;
      miss = (hit_at == n);

      if (policy_q == POLICY_FIFO) begin
        if (miss) begin
          if (!frame_valid[fifo_ptr] && filled < n) filled++;
          frame_page[fifo_ptr]  = pg;
          frame_valid[fifo_ptr] = 1'b1;
          fifo_ptr = (fifo_ptr + 1 >= n) ? '0 : SLOT_W'(fifo_ptr + 1);
        end
      end else if (!miss) begin
        // move the hit page to the newest end of the recency stack
        for (int k = hit_at; k + 1 < filled; k++) frame_page[k] = frame_page[k + 1];
        if (filled > 0) frame_page[filled - 1] = pg;
      end else if (filled < n) begin
        frame_page[filled]  = pg;
        frame_valid[filled] = 1'b1;
        filled++;
      end else begin
        // shift out the oldest page
        for (int k = 0; k + 1 < n; k++) frame_page[k] = frame_page[k + 1];
        frame_page[n - 1] = pg;
      end

      count_before = fault_cnt;
      if (miss && fault_cnt != FAULT_MAX) fault_cnt++;

      for (int k = 0; k < n; k++) begin
        r.slot = SLOT_W'(k);
        r.pg   = frame_valid[k] ? frame_page[k] : '0;
        r.vld  = frame_valid[k];
        r.flt  = miss;
        r.fnum = count_before;
        r.lst  = (k + 1 == n);
        report_q.push_back(r);
      end
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compare one accepted report word with the oldest one owed
    function void check_report(report_t got);
      report_t want;
      if (report_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected report word: expected none, actual slot %0d page %0d",
                 $time, got.slot, got.pg);
        return;
      end
      want = report_q.pop_front();
      cmp_field("slot", want.slot, got.slot);
      cmp_field("slot_page", want.pg, got.pg);
      cmp_field("slot_valid", want.vld, got.vld);
      cmp_field("fault", want.flt, got.flt);
      cmp_field("fault_number", want.fnum, got.fnum);
      cmp_field("last", want.lst, got.lst);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic                 op = OP_REF;
  logic [PAGE_W-1:0]    page = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [SLOT_W-1:0]    slot;
  logic [PAGE_W-1:0]    slot_page;
  logic                 slot_valid;
  logic                 fault;
  logic [FAULT_W-1:0]   fault_number;
  logic                 last;
  logic                 wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = REG_POLICY;
  logic [FC_W-1:0]      wr_data = '0;

  bit                    gaps_on = 1'b1;
  bit                    stalls_on = 1'b1;
  int                    idle_cycles = 0;
  frame_table_scoreboard sb;

  page_replacement_fifo_lru u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .page         (page),
    .empty        (empty),
    .pop          (pop),
    .slot         (slot),
    .slot_page    (slot_page),
    .slot_valid   (slot_valid),
    .fault        (fault),
    .fault_number (fault_number),
    .last         (last),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  always #5 clk = ~clk;

  // Stall the result side at random
  always @(negedge clk) begin
    pop <= !stalls_on || ($urandom_range(0, 99) >= STALL_PCT);
  end

  // Check every accepted report word
  always @(posedge clk) begin
    report_t got;
    if (!rst && pop && !empty) begin
      got.slot = slot;
      got.pg   = slot_page;
      got.vld  = slot_valid;
      got.flt  = fault;
      got.fnum = fault_number;
      got.lst  = last;
      sb.check_report(got);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one word, idling at random first; called and returns at a falling edge
  task automatic send_word(input logic o, input logic [PAGE_W-1:0] p);
    while (gaps_on && $urandom_range(0, 99) < STALL_PCT) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    op   <= o;
    page <= p;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    sb.predict_frames(o, p);
    @(negedge clk);
  endtask

  // Hold off the sender until every owed report has come, then let clears settle
  task automatic drain();
    push <= 1'b0;
    while (sb.report_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [FC_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic pol, input logic [FC_W-1:0] fc);
    drain();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_POLICY, FC_W'(pol));
      write_reg(REG_FRAME_COUNT, fc);
    end else begin
      write_reg(REG_FRAME_COUNT, fc);
      write_reg(REG_POLICY, {(FC_W-1)'($urandom_range(0, 7)), pol});
    end
  endtask

  initial begin
    logic [FC_W-1:0]   fc;
    logic [PAGE_W-1:0] ws_base;
    logic [PAGE_W-1:0] pg;
    int                span;

    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // FIFO, three frames: fill, hit, wrap-around replacement, clear
    configure(POLICY_FIFO, FC_W'(3));
    send_word(OP_REF, 8'h00);
    send_word(OP_REF, 8'hFF);
    send_word(OP_REF, 8'h00);
    send_word(OP_REF, 8'hAA);
    send_word(OP_REF, 8'h55);
    send_word(OP_REF, 8'h00);
    send_word(OP_CLEAR, 8'hFF);
    send_word(OP_REF, 8'h55);

    // LRU, four frames: fill, hit on the oldest, shift out oldest, hit on newest
    configure(POLICY_LRU, FC_W'(4));
    send_word(OP_REF, 8'h01);
    send_word(OP_REF, 8'h02);
    send_word(OP_REF, 8'h03);
    send_word(OP_REF, 8'h01);
    send_word(OP_REF, 8'h04);
    send_word(OP_REF, 8'h05);
    send_word(OP_REF, 8'h05);
    send_word(OP_REF, 8'h02);

    // frame count zero acts as one frame
    configure(POLICY_LRU, FC_W'(0));
    send_word(OP_REF, 8'h07);
    send_word(OP_REF, 8'h07);
    send_word(OP_REF, 8'h08);

    // frame counts past the table act as the full table
    configure(POLICY_FIFO, FC_W'(15));
    send_word(OP_REF, 8'h3C);
    send_word(OP_REF, 8'hC3);
    configure(POLICY_LRU, FC_W'(9));
    send_word(OP_REF, 8'h81);
    send_word(OP_REF, 8'h18);

    // Random phases: references mostly from a small working set so hits are common
    for (int ph = 0; ph < 5; ph++) begin
      fc = (ph == 0) ? FC_W'(MAX_FRAMES) : (ph == 1) ? FC_W'(1) : FC_W'($urandom_range(0, 15));
      configure(logic'($urandom_range(0, 1)), fc);
      gaps_on   = (ph != 2);
      stalls_on = (ph != 2);
      span      = sb.frames_in_use() + 2;
      ws_base   = PAGE_W'($urandom_range(0, 255));
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (ph == 1 && i == 11) drain();
        if ($urandom_range(0, 99) < 75) pg = PAGE_W'(ws_base + $urandom_range(0, span - 1));
        else pg = PAGE_W'($urandom_range(0, 255));
        if ($urandom_range(0, 19) == 0) send_word(OP_CLEAR, pg);
        else send_word(OP_REF, pg);
      end
    end

    // Clear, then miss and hit on one page
    send_word(OP_CLEAR, 8'h00);
    send_word(OP_REF, 8'h5A);
    send_word(OP_REF, 8'h5A);

    drain();
    repeat (16) @(negedge clk);
    if (sb.errors == 0 && sb.report_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
